>>> hdl/i2c_bus_clear_supervisor_macros.svh
// assertion macros for the bus clear supervisor
`ifndef I2C_BUS_CLEAR_SUPERVISOR_MACROS_SVH
`define I2C_BUS_CLEAR_SUPERVISOR_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled during reset
`define BCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bus clear supervisor: same-cycle check failed");

// next-cycle implication, disabled during reset
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bus clear supervisor: next-cycle check failed");

`else

`define BCS_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/i2cbc_pkg.sv
`timescale 1ns / 1ps

package i2cbc_pkg;

	typedef enum logic [3:0] {
		PH_IDLE        = 4'd0,
		PH_PULSE_LOW   = 4'd1,
		PH_PULSE_WAIT  = 4'd2,
		PH_PULSE_HIGH  = 4'd3,
		PH_STOP_SCL_LO = 4'd4,
		PH_STOP_SDA_LO = 4'd5,
		PH_STOP_WAIT   = 4'd6,
		PH_STOP_SCL_HI = 4'd7,
		PH_STOP_SDA_HI = 4'd8
	} phase_t;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_ERROR = 2'd1,
		CMD_ACK   = 2'd2,
		CMD_FORCE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		REG_HALF_PERIOD   = 2'd0,
		REG_STRETCH_LIMIT = 2'd1,
		REG_ERROR_LIMIT   = 2'd2,
		REG_PULSE_LIMIT   = 2'd3
	} reg_idx_t;

	localparam logic [15:0] HALF_PERIOD_RST   = 16'd80;
	localparam logic [15:0] STRETCH_LIMIT_RST = 16'd1000;
	localparam logic [3:0]  ERROR_LIMIT_RST   = 4'd5;
	localparam logic [4:0]  PULSE_LIMIT_RST   = 5'd16;

	localparam logic [3:0]  ERR_COUNT_MAX  = 4'd15;
	localparam logic [4:0]  PULSE_CNT_MAX  = 5'd31;

endpackage

>>> hdl/i2c_bus_clear_supervisor.sv
`timescale 1ns / 1ps
`include "i2c_bus_clear_supervisor_macros.svh"

// channel   direction  handshake            payload
// input     in         in_valid / in_stall  cmd, scl_level, sda_level
// output    out        out_valid / out_stall scl_pull_low, sda_pull_low, recovering,
//                                           recovery_done, errors_seen
// config    in/out     apb psel/penable     paddr[3:0], pwdata, prdata
//
// one transfer per clock sustained while the output does not stall; a tick goes
// through the input register and the sequencer update into the result register
// the sequencer state is updated only when a tick moves into the result register
// arst_n clears the state, the valid flags and loads the register defaults
// a stalled output holds the result while the input register still takes one more
// tick; in_stall rises only when both registers are full and the output is stalled

module i2c_bus_clear_supervisor (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  cmd,
	input  logic        scl_level,
	input  logic        sda_level,

	output logic        out_valid,
	input  logic        out_stall,
	output logic        scl_pull_low,
	output logic        sda_pull_low,
	output logic        recovering,
	output logic        recovery_done,
	output logic [3:0]  errors_seen,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	// configuration registers
	logic [15:0] half_period_q;
	logic [15:0] stretch_limit_q;
	logic [3:0]  error_limit_q;
	logic [4:0]  pulse_limit_q;

	logic                  cfg_wr;
	i2cbc_pkg::reg_idx_t   cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = i2cbc_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q   <= i2cbc_pkg::HALF_PERIOD_RST;
			stretch_limit_q <= i2cbc_pkg::STRETCH_LIMIT_RST;
			error_limit_q   <= i2cbc_pkg::ERROR_LIMIT_RST;
			pulse_limit_q   <= i2cbc_pkg::PULSE_LIMIT_RST;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				i2cbc_pkg::REG_HALF_PERIOD:   half_period_q   <= pwdata[15:0];
				i2cbc_pkg::REG_STRETCH_LIMIT: stretch_limit_q <= pwdata[15:0];
				i2cbc_pkg::REG_ERROR_LIMIT:   error_limit_q   <= pwdata[3:0];
				i2cbc_pkg::REG_PULSE_LIMIT:   pulse_limit_q   <= pwdata[4:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			i2cbc_pkg::REG_HALF_PERIOD:   prdata = {16'd0, half_period_q};
			i2cbc_pkg::REG_STRETCH_LIMIT: prdata = {16'd0, stretch_limit_q};
			i2cbc_pkg::REG_ERROR_LIMIT:   prdata = {28'd0, error_limit_q};
			i2cbc_pkg::REG_PULSE_LIMIT:   prdata = {27'd0, pulse_limit_q};
			default:                      prdata = 32'd0;
		endcase
	end

	// input register
	logic               valid_s1;
	i2cbc_pkg::cmd_t    cmd_s1;
	logic               scl_s1;
	logic               sda_s1;

	// result register
	logic        valid_s2;
	logic        scl_low_s2;
	logic        sda_low_s2;
	logic        recovering_s2;
	logic        done_s2;
	logic [3:0]  errors_s2;

	logic advance;   // tick in s1 moves into the result register this cycle
	logic take_in;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1 <= i2cbc_pkg::cmd_t'(cmd);
			scl_s1 <= scl_level;
			sda_s1 <= sda_level;
		end
	end

	// sequencer state
	i2cbc_pkg::phase_t phase_q, phase_d;
	logic [15:0] wait_count_q, wait_count_d;
	logic [15:0] stretch_count_q, stretch_count_d;
	logic [4:0]  pulses_given_q, pulses_given_d;
	logic [3:0]  error_count_q, error_count_d;
	logic        done_d;

	logic [15:0] wait_inc;
	logic [15:0] stretch_inc;
	logic        hold_fin;
	logic        stretch_fin;
	logic [3:0]  err_inc;
	logic [4:0]  pulse_inc;

	// hold and stretch counters wrap at 16 bits; a wrap also ends the phase
	assign wait_inc    = wait_count_q + 16'd1;
	assign stretch_inc = stretch_count_q + 16'd1;
	assign hold_fin    = (wait_inc >= half_period_q) || (wait_inc == 16'd0);
	assign stretch_fin = scl_s1 || (stretch_inc >= stretch_limit_q) || (stretch_inc == 16'd0);
	assign err_inc     = (error_count_q < i2cbc_pkg::ERR_COUNT_MAX) ?
	                     error_count_q + 4'd1 : error_count_q;
	assign pulse_inc   = (pulses_given_q < i2cbc_pkg::PULSE_CNT_MAX) ?
	                     pulses_given_q + 5'd1 : pulses_given_q;

	// next state
	always_comb begin
		phase_d         = phase_q;
		wait_count_d    = wait_count_q;
		stretch_count_d = stretch_count_q;
		pulses_given_d  = pulses_given_q;
		error_count_d   = error_count_q;
		done_d          = 1'b0;

		unique case (phase_q)
			i2cbc_pkg::PH_IDLE: begin
				// events only count while idle
				priority case (cmd_s1)
					i2cbc_pkg::CMD_ERROR: begin
						error_count_d = err_inc;
						if (err_inc >= error_limit_q) begin
							phase_d        = i2cbc_pkg::PH_PULSE_LOW;
							pulses_given_d = 5'd0;
							wait_count_d    = 16'd0;
							stretch_count_d = 16'd0;
						end
					end
					i2cbc_pkg::CMD_ACK: begin
						error_count_d = 4'd0;
					end
					i2cbc_pkg::CMD_FORCE: begin
						phase_d         = i2cbc_pkg::PH_PULSE_LOW;
						pulses_given_d  = 5'd0;
						wait_count_d    = 16'd0;
						stretch_count_d = 16'd0;
					end
					default: ;
				endcase
			end
			i2cbc_pkg::PH_PULSE_LOW: begin
				wait_count_d = wait_inc;
				if (hold_fin) begin
					phase_d         = i2cbc_pkg::PH_PULSE_WAIT;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
				end
			end
			i2cbc_pkg::PH_PULSE_WAIT: begin
				if (!scl_s1) begin
					stretch_count_d = stretch_inc;
				end
				if (stretch_fin) begin
					phase_d         = i2cbc_pkg::PH_PULSE_HIGH;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
				end
			end
			i2cbc_pkg::PH_PULSE_HIGH: begin
				wait_count_d = wait_inc;
				if (hold_fin) begin
					pulses_given_d  = pulse_inc;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
					// sda released by the target, or out of pulses: go to stop
					if (sda_s1 || (pulse_inc >= pulse_limit_q)) begin
						phase_d = i2cbc_pkg::PH_STOP_SCL_LO;
					end else begin
						phase_d = i2cbc_pkg::PH_PULSE_LOW;
					end
				end
			end
			i2cbc_pkg::PH_STOP_SCL_LO: begin
				wait_count_d = wait_inc;
				if (hold_fin) begin
					phase_d         = i2cbc_pkg::PH_STOP_SDA_LO;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
				end
			end
			i2cbc_pkg::PH_STOP_SDA_LO: begin
				wait_count_d = wait_inc;
				if (hold_fin) begin
					phase_d         = i2cbc_pkg::PH_STOP_WAIT;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
				end
			end
			i2cbc_pkg::PH_STOP_WAIT: begin
				if (!scl_s1) begin
					stretch_count_d = stretch_inc;
				end
				if (stretch_fin) begin
					phase_d         = i2cbc_pkg::PH_STOP_SCL_HI;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
				end
			end
			i2cbc_pkg::PH_STOP_SCL_HI: begin
				wait_count_d = wait_inc;
				if (hold_fin) begin
					phase_d         = i2cbc_pkg::PH_STOP_SDA_HI;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
				end
			end
			i2cbc_pkg::PH_STOP_SDA_HI: begin
				wait_count_d = wait_inc;
				if (hold_fin) begin
					// sequence complete: controller gets reset, count starts over
					phase_d         = i2cbc_pkg::PH_IDLE;
					wait_count_d    = 16'd0;
					stretch_count_d = 16'd0;
					pulses_given_d  = 5'd0;
					error_count_d   = 4'd0;
					done_d          = 1'b1;
				end
			end
			default: begin
				phase_d         = i2cbc_pkg::PH_IDLE;
				wait_count_d    = 16'd0;
				stretch_count_d = 16'd0;
			end
		endcase
	end

	// pin drive for the phase entered on this tick
	logic scl_low_d;
	logic sda_low_d;

	always_comb begin
		unique case (phase_d)
			i2cbc_pkg::PH_PULSE_LOW,
			i2cbc_pkg::PH_STOP_SCL_LO: begin
				scl_low_d = 1'b1;
				sda_low_d = 1'b0;
			end
			i2cbc_pkg::PH_STOP_SDA_LO: begin
				scl_low_d = 1'b1;
				sda_low_d = 1'b1;
			end
			i2cbc_pkg::PH_STOP_WAIT,
			i2cbc_pkg::PH_STOP_SCL_HI: begin
				scl_low_d = 1'b0;
				sda_low_d = 1'b1;
			end
			default: begin
				scl_low_d = 1'b0;
				sda_low_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= i2cbc_pkg::PH_IDLE;
			wait_count_q    <= 16'd0;
			stretch_count_q <= 16'd0;
			pulses_given_q  <= 5'd0;
			error_count_q   <= 4'd0;
		end else if (advance) begin
			phase_q         <= phase_d;
			wait_count_q    <= wait_count_d;
			stretch_count_q <= stretch_count_d;
			pulses_given_q  <= pulses_given_d;
			error_count_q   <= error_count_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			scl_low_s2    <= scl_low_d;
			sda_low_s2    <= sda_low_d;
			recovering_s2 <= (phase_d != i2cbc_pkg::PH_IDLE);
			done_s2       <= done_d;
			errors_s2     <= error_count_d;
		end
	end

	assign out_valid     = valid_s2;
	assign scl_pull_low  = scl_low_s2;
	assign sda_pull_low  = sda_low_s2;
	assign recovering    = recovering_s2;
	assign recovery_done = done_s2;
	assign errors_seen   = errors_s2;

	// checks
	`BCS_ASSERT_IMPL(a_done_clears, clk, arst_n, out_valid && recovery_done, !recovering && (errors_seen == 4'd0))
	`BCS_ASSERT_IMPL(a_pins_only_busy, clk, arst_n, out_valid && (scl_pull_low || sda_pull_low), recovering)
	`BCS_ASSERT_IMPL(a_idle_counters, clk, arst_n, phase_q == i2cbc_pkg::PH_IDLE, (wait_count_q == 16'd0) && (stretch_count_q == 16'd0) && (pulses_given_q == 5'd0))
	`BCS_ASSERT_NEXT(a_stall_keeps_s1, clk, arst_n, in_stall, valid_s1)

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

	// run length guard, far above the slowest legal run
	localparam int CYCLE_LIMIT    = 2000000;
	// percent of cycles in which each side holds off
	localparam int IDLE_PCT       = 22;
	localparam int RAND_PER_PHASE = 90;
	localparam int RAND_PHASES    = 8;

	// one sampled bus tick as it goes into the block
	typedef struct packed {
		i2cbc_pkg::cmd_t cmd;
		logic            scl;
		logic            sda;
	} bus_tick_t;

	// outputs the block shows after one tick
	typedef struct packed {
		logic       scl_low;
		logic       sda_low;
		logic       busy;
		logic       done;
		logic [3:0] errs;
	} clear_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;

	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  cmd = i2cbc_pkg::CMD_TICK;
	logic        scl_level = 1'b1;
	logic        sda_level = 1'b1;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        scl_pull_low;
	logic        sda_pull_low;
	logic        recovering;
	logic        recovery_done;
	logic [3:0]  errors_seen;

	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	i2c_bus_clear_supervisor DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.scl_level     (scl_level),
		.sda_level     (sda_level),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.scl_pull_low  (scl_pull_low),
		.sda_pull_low  (sda_pull_low),
		.recovering    (recovering),
		.recovery_done (recovery_done),
		.errors_seen   (errors_seen),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	// 8 ns clock
	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// predictor state: a private copy of the sequencer and its registers
	// ---------------------------------------------------------------
	i2cbc_pkg::phase_t seq_phase = i2cbc_pkg::PH_IDLE;
	logic [15:0] hold_ticks = '0;
	logic [15:0] stretch_ticks = '0;
	logic [4:0]  pulse_cnt = '0;
	logic [3:0]  err_cnt = '0;

	logic [15:0] cfg_half = i2cbc_pkg::HALF_PERIOD_RST;
	logic [15:0] cfg_stretch = i2cbc_pkg::STRETCH_LIMIT_RST;
	logic [3:0]  cfg_err_limit = i2cbc_pkg::ERROR_LIMIT_RST;
	logic [4:0]  cfg_pulse_limit = i2cbc_pkg::PULSE_LIMIT_RST;

	// ticks waiting to be driven, and bus states waiting to be seen
	bus_tick_t     bus_ticks[$];
	clear_status_t pending_status[$];

	int          ticks_sent = 0;
	int          ticks_taken = 0;
	int          mismatches = 0;
	int          cycle_cnt = 0;
	bit          calm = 1'b0;
	bus_tick_t   drv_tick;

	// every phase change restarts both counters
	function automatic void enter_phase(i2cbc_pkg::phase_t p);
		seq_phase     = p;
		hold_ticks    = '0;
		stretch_ticks = '0;
	endfunction

	// a timed hold ends at the half period, or on counter wrap
	function automatic logic hold_elapsed();
		hold_ticks = hold_ticks + 16'd1;
		return (hold_ticks >= cfg_half) || (hold_ticks == 16'd0);
	endfunction

	// a stretch wait ends on scl high or after the limit of low samples
	function automatic logic stretch_elapsed(logic scl);
		if (scl)
			return 1'b1;
		stretch_ticks = stretch_ticks + 16'd1;
		return (stretch_ticks >= cfg_stretch) || (stretch_ticks == 16'd0);
	endfunction

	function automatic void start_clear();
		pulse_cnt = '0;
		enter_phase(i2cbc_pkg::PH_PULSE_LOW);
	endfunction

	// advance the sequencer by one tick and return what the pins show
	function automatic clear_status_t step_bus_clear(i2cbc_pkg::cmd_t c, logic scl,
			logic sda);
		clear_status_t s;
		s = '0;
		case (seq_phase)
			i2cbc_pkg::PH_IDLE: begin
				// events only count while idle
				if (c == i2cbc_pkg::CMD_ERROR) begin
					if (err_cnt < i2cbc_pkg::ERR_COUNT_MAX)
						err_cnt = err_cnt + 4'd1;
					if (err_cnt >= cfg_err_limit)
						start_clear();
				end else if (c == i2cbc_pkg::CMD_ACK) begin
					err_cnt = '0;
				end else if (c == i2cbc_pkg::CMD_FORCE) begin
					start_clear();
				end
			end
			i2cbc_pkg::PH_PULSE_LOW: begin
				if (hold_elapsed())
					enter_phase(i2cbc_pkg::PH_PULSE_WAIT);
			end
			i2cbc_pkg::PH_PULSE_WAIT: begin
				if (stretch_elapsed(scl))
					enter_phase(i2cbc_pkg::PH_PULSE_HIGH);
			end
			i2cbc_pkg::PH_PULSE_HIGH: begin
				// sda sampled at the end of the high hold
				if (hold_elapsed()) begin
					if (pulse_cnt < i2cbc_pkg::PULSE_CNT_MAX)
						pulse_cnt = pulse_cnt + 5'd1;
					if (sda || pulse_cnt >= cfg_pulse_limit)
						enter_phase(i2cbc_pkg::PH_STOP_SCL_LO);
					else
						enter_phase(i2cbc_pkg::PH_PULSE_LOW);
				end
			end
			i2cbc_pkg::PH_STOP_SCL_LO: begin
				if (hold_elapsed())
					enter_phase(i2cbc_pkg::PH_STOP_SDA_LO);
			end
			i2cbc_pkg::PH_STOP_SDA_LO: begin
				if (hold_elapsed())
					enter_phase(i2cbc_pkg::PH_STOP_WAIT);
			end
			i2cbc_pkg::PH_STOP_WAIT: begin
				if (stretch_elapsed(scl))
					enter_phase(i2cbc_pkg::PH_STOP_SCL_HI);
			end
			i2cbc_pkg::PH_STOP_SCL_HI: begin
				if (hold_elapsed())
					enter_phase(i2cbc_pkg::PH_STOP_SDA_HI);
			end
			i2cbc_pkg::PH_STOP_SDA_HI: begin
				if (hold_elapsed()) begin
					enter_phase(i2cbc_pkg::PH_IDLE);
					pulse_cnt = '0;
					err_cnt   = '0;
					s.done    = 1'b1;
				end
			end
			default: begin
				enter_phase(i2cbc_pkg::PH_IDLE);
			end
		endcase
		case (seq_phase)
			i2cbc_pkg::PH_PULSE_LOW, i2cbc_pkg::PH_STOP_SCL_LO: begin
				s.scl_low = 1'b1;
			end
			i2cbc_pkg::PH_STOP_SDA_LO: begin
				s.scl_low = 1'b1;
				s.sda_low = 1'b1;
			end
			i2cbc_pkg::PH_STOP_WAIT, i2cbc_pkg::PH_STOP_SCL_HI: begin
				s.sda_low = 1'b1;
			end
			default: begin
			end
		endcase
		s.busy = (seq_phase != i2cbc_pkg::PH_IDLE);
		s.errs = err_cnt;
		return s;
	endfunction

	task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %0d actual %0d", $time, name, want, got);
			mismatches++;
		end
	endtask

	// ---------------------------------------------------------------
	// driver: new values at the falling edge
	// ---------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			// previous transfer done (or none open): pick the next tick or idle
			if (ticks_taken == ticks_sent) begin
				if (bus_ticks.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					drv_tick = bus_ticks.pop_front();
					in_valid  <= 1'b1;
					cmd       <= drv_tick.cmd;
					scl_level <= drv_tick.scl;
					sda_level <= drv_tick.sda;
					ticks_sent = ticks_sent + 1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			// receiver back-pressure
			out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// ---------------------------------------------------------------
	// predictor and monitor: sample at the rising edge
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		clear_status_t want;
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("i2c_bus_clear_supervisor test failed");
			$finish;
		end else if (arst_n) begin
			// accepted tick: predict the bus state it leads to
			if (in_valid && !in_stall) begin
				pending_status.push_back(step_bus_clear(i2cbc_pkg::cmd_t'(cmd),
					scl_level, sda_level));
				ticks_taken <= ticks_taken + 1;
			end
			// accepted result: compare with the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_status.size() == 0) begin
					$display("%0t ns: result transfer with nothing expected", $time);
					mismatches++;
				end else begin
					want = pending_status.pop_front();
					check_field("scl_pull_low", 4'(want.scl_low), 4'(scl_pull_low));
					check_field("sda_pull_low", 4'(want.sda_low), 4'(sda_pull_low));
					check_field("recovering", 4'(want.busy), 4'(recovering));
					check_field("recovery_done", 4'(want.done), 4'(recovery_done));
					check_field("errors_seen", want.errs, errors_seen);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	task automatic queue_tick(i2cbc_pkg::cmd_t c, logic scl, logic sda);
		bus_ticks.push_back('{c, scl, sda});
	endtask

	function automatic bus_tick_t random_tick(int scl_pct, int sda_pct);
		bus_tick_t t;
		int        r;
		r = $urandom_range(99);
		if (r < 58)
			t.cmd = i2cbc_pkg::CMD_TICK;
		else if (r < 80)
			t.cmd = i2cbc_pkg::CMD_ERROR;
		else if (r < 88)
			t.cmd = i2cbc_pkg::CMD_ACK;
		else
			t.cmd = i2cbc_pkg::CMD_FORCE;
		t.scl = ($urandom_range(99) < scl_pct);
		t.sda = ($urandom_range(99) < sda_pct);
		return t;
	endfunction

	// wait until every tick went in and every result came out, plus latency
	task automatic drain();
		while (bus_ticks.size() != 0 || ticks_sent != ticks_taken || pending_status.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// run any open bus clear to its end with a free bus, so registers can change
	task automatic settle();
		drain();
		while (seq_phase != i2cbc_pkg::PH_IDLE) begin
			repeat (16) queue_tick(i2cbc_pkg::CMD_TICK, 1'b1, 1'b1);
			drain();
		end
	endtask

	// apb write: setup cycle, then access cycle; upper data bits are junk
	task automatic write_reg(i2cbc_pkg::reg_idx_t idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			i2cbc_pkg::REG_HALF_PERIOD:   cfg_half        = value[15:0];
			i2cbc_pkg::REG_STRETCH_LIMIT: cfg_stretch     = value[15:0];
			i2cbc_pkg::REG_ERROR_LIMIT:   cfg_err_limit   = value[3:0];
			i2cbc_pkg::REG_PULSE_LIMIT:   cfg_pulse_limit = value[4:0];
			default: begin
			end
		endcase
	endtask

	task automatic write_all(logic [15:0] half, logic [15:0] stretch, logic [3:0] errs,
			logic [4:0] pulses);
		write_reg(i2cbc_pkg::REG_HALF_PERIOD, {16'($urandom), half});
		write_reg(i2cbc_pkg::REG_STRETCH_LIMIT, {16'($urandom), stretch});
		write_reg(i2cbc_pkg::REG_ERROR_LIMIT, {28'($urandom), errs});
		write_reg(i2cbc_pkg::REG_PULSE_LIMIT, {27'($urandom), pulses});
	endtask

	// ---------------------------------------------------------------
	// test sequence
	// ---------------------------------------------------------------
	initial begin
		int calm_phase;
		calm_phase = $urandom_range(RAND_PHASES - 1);

		// single reset at start
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// reset defaults: all pin combinations, count and clear, then limit reached
		queue_tick(i2cbc_pkg::CMD_TICK, 1'b0, 1'b0);
		queue_tick(i2cbc_pkg::CMD_TICK, 1'b1, 1'b0);
		queue_tick(i2cbc_pkg::CMD_TICK, 1'b0, 1'b1);
		queue_tick(i2cbc_pkg::CMD_TICK, 1'b1, 1'b1);
		queue_tick(i2cbc_pkg::CMD_ACK, 1'b1, 1'b1);
		queue_tick(i2cbc_pkg::CMD_ERROR, 1'b1, 1'b1);
		queue_tick(i2cbc_pkg::CMD_ERROR, 1'b0, 1'b1);
		queue_tick(i2cbc_pkg::CMD_ACK, 1'b1, 1'b0);
		repeat (5) queue_tick(i2cbc_pkg::CMD_ERROR, 1'b1, 1'b1);
		// events during the sequence are ignored
		queue_tick(i2cbc_pkg::CMD_ERROR, 1'b1, 1'b1);
		queue_tick(i2cbc_pkg::CMD_ACK, 1'b1, 1'b1);
		queue_tick(i2cbc_pkg::CMD_FORCE, 1'b1, 1'b1);
		settle();

		// zero half period acts as one; forced clear keeps the count
		write_all(16'd0, 16'd2, 4'd3, 5'd2);
		queue_tick(i2cbc_pkg::CMD_ERROR, 1'b1, 1'b1);
		queue_tick(i2cbc_pkg::CMD_FORCE, 1'b1, 1'b1);
		// scl held low long enough to hit the stretch timeout
		repeat (4) queue_tick(i2cbc_pkg::CMD_TICK, 1'b0, 1'b0);
		// sda low at the end of the high hold asks for another pulse
		repeat (3) queue_tick(i2cbc_pkg::CMD_TICK, 1'b1, 1'b0);
		repeat (8) queue_tick(i2cbc_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();

		// random phases; the first one pins register extremes
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			int scl_pct;
			int sda_pct;
			calm = (ph == calm_phase);
			if (ph == 0) begin
				write_all(16'd1, 16'hFFFF, 4'd0, 5'd31);
				sda_pct = 3;
			end else begin
				write_all(16'($urandom_range(5)),
					($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom_range(8)),
					4'($urandom_range(15)),
					($urandom_range(3) == 0) ? 5'd31 : 5'($urandom_range(6)));
				sda_pct = $urandom_range(80, 20);
			end
			scl_pct = $urandom_range(95, 40);
			repeat (RAND_PER_PHASE) bus_ticks.push_back(random_tick(scl_pct, sda_pct));
			// sender pause: all results in before the bus is freed
			settle();
		end
		calm = 1'b0;

		// long stretch waits with scl stuck low; zero stretch limit first
		write_all(16'd1, 16'd0, 4'd1, 5'd0);
		queue_tick(i2cbc_pkg::CMD_ERROR, 1'b0, 1'b0);
		repeat (6) queue_tick(i2cbc_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();
		write_reg(i2cbc_pkg::REG_STRETCH_LIMIT, {16'($urandom), 16'd60});
		write_reg(i2cbc_pkg::REG_PULSE_LIMIT, {27'($urandom), 5'd1});
		queue_tick(i2cbc_pkg::CMD_FORCE, 1'b0, 1'b0);
		repeat (130) queue_tick(i2cbc_pkg::CMD_TICK, 1'b0, 1'b0);
		settle();

		// largest half period while only counting, up to one below the error limit
		write_all(16'hFFFF, 16'd3, 4'd15, 5'd3);
		repeat (14) queue_tick(i2cbc_pkg::CMD_ERROR, 1'b1, 1'b0);
		queue_tick(i2cbc_pkg::CMD_ACK, 1'b0, 1'b1);
		repeat (3) queue_tick(i2cbc_pkg::CMD_ERROR, 1'b0, 1'b0);
		queue_tick(i2cbc_pkg::CMD_ACK, 1'b1, 1'b1);
		drain();

		// fifteen errors reach the highest limit
		write_reg(i2cbc_pkg::REG_HALF_PERIOD, {16'($urandom), 16'd2});
		repeat (15) queue_tick(i2cbc_pkg::CMD_ERROR, 1'b1, 1'b1);
		settle();

		if (mismatches == 0)
			$display("i2c_bus_clear_supervisor test passed");
		else
			$display("i2c_bus_clear_supervisor test failed");
		$finish;
	end

endmodule
